### hw/rtl/vdq_pkg.sv
// Package for the sixteen-sector vector direction quantizer.
// Holds the Q10 direction table, field widths and shared types; depends on nothing.
package vdq_pkg;

  localparam int FIELD_W      = 16;
  localparam int SECTOR_COUNT = 16;
  localparam int SECTOR_W     = 4;
  localparam int MAG_COUNT    = 4;

  typedef logic [SECTOR_W-1:0] sector_t;

  // Distinct nonzero magnitudes of the Q10 unit-vector components.
  localparam int Q10_MAG [MAG_COUNT] = '{1024, 946, 724, 392};

  // Direction k points at k * 22.5 degrees, counterclockwise from +x.
  localparam int DIR_X_Q10 [SECTOR_COUNT] = '{
    1024, 946, 724, 392, 0, -392, -724, -946,
    -1024, -946, -724, -392, 0, 392, 724, 946
  };
  localparam int DIR_Y_Q10 [SECTOR_COUNT] = '{
    0, 392, 724, 946, 1024, 946, 724, 392,
    0, -392, -724, -946, -1024, -946, -724, -392
  };

  // Map a table coefficient to the slot of its magnitude in Q10_MAG.
  function automatic int mag_sel(input int coef);
    int sel;
    sel = 0;
    for (int i = 0; i < MAG_COUNT; i++) begin
      if (coef == Q10_MAG[i] || coef == -Q10_MAG[i]) begin
        sel = i;
      end
    end
    return sel;
  endfunction

endpackage

### hw/rtl/vdq_dot.sv
// Dot products of one vector with all sixteen Q10 directions, two register stages.
// Depends on vdq_pkg for the direction table and magnitudes.
module vdq_dot #(
  parameter int COMPONENT_WIDTH = 16,
  localparam int DotW = COMPONENT_WIDTH + 12
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic signed [COMPONENT_WIDTH-1:0] in_x,
  input  logic signed [COMPONENT_WIDTH-1:0] in_y,
  output logic                              out_valid,
  output logic signed [DotW-1:0]            out_dot [vdq_pkg::SECTOR_COUNT]
);
  import vdq_pkg::*;

  localparam int ProdW = COMPONENT_WIDTH + 11;

  logic signed [ProdW-1:0] x_ext;
  logic signed [ProdW-1:0] y_ext;
  logic signed [ProdW-1:0] px_nxt [MAG_COUNT];
  logic signed [ProdW-1:0] py_nxt [MAG_COUNT];
  logic signed [ProdW-1:0] px_r   [MAG_COUNT];
  logic signed [ProdW-1:0] py_r   [MAG_COUNT];
  logic                    prod_v_r;
  logic signed [DotW-1:0]  tx     [SECTOR_COUNT];
  logic signed [DotW-1:0]  ty     [SECTOR_COUNT];
  logic signed [DotW-1:0]  dot_nxt [SECTOR_COUNT];
  logic signed [DotW-1:0]  dot_r   [SECTOR_COUNT];
  logic                    dot_v_r;

  assign x_ext = ProdW'(in_x);
  assign y_ext = ProdW'(in_y);

  // Constant-coefficient products: only four magnitudes per component.
  always_comb begin
    for (int i = 0; i < MAG_COUNT; i++) begin
      px_nxt[i] = x_ext * ProdW'(Q10_MAG[i]);
      py_nxt[i] = y_ext * ProdW'(Q10_MAG[i]);
    end
  end

  always_ff @(posedge clk) begin
    px_r <= px_nxt;
    py_r <= py_nxt;
  end

  // Pick sign and magnitude of each term per direction at elaboration.
  for (genvar k = 0; k < SECTOR_COUNT; k++) begin : g_dir
    localparam int XC = DIR_X_Q10[k];
    localparam int YC = DIR_Y_Q10[k];
    localparam int XS = mag_sel(XC);
    localparam int YS = mag_sel(YC);

    if (XC == 0) begin : g_x0
      assign tx[k] = '0;
    end else if (XC > 0) begin : g_xp
      assign tx[k] = DotW'(px_r[XS]);
    end else begin : g_xn
      assign tx[k] = -DotW'(px_r[XS]);
    end

    if (YC == 0) begin : g_y0
      assign ty[k] = '0;
    end else if (YC > 0) begin : g_yp
      assign ty[k] = DotW'(py_r[YS]);
    end else begin : g_yn
      assign ty[k] = -DotW'(py_r[YS]);
    end

    assign dot_nxt[k] = tx[k] + ty[k];
  end

  always_ff @(posedge clk) begin
    dot_r <= dot_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_v_r <= 1'b0;
      dot_v_r  <= 1'b0;
    end else begin
      prod_v_r <= in_valid;
      dot_v_r  <= prod_v_r;
    end
  end

  assign out_valid = dot_v_r;
  assign out_dot   = dot_r;

endmodule

### hw/rtl/vdq_argmax.sv
// Registered compare tree: index of the largest of sixteen dot products, lowest index on ties.
// Depends on vdq_pkg for the sector count and index type.
module vdq_argmax #(
  parameter int DOT_WIDTH = 28
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic signed [DOT_WIDTH-1:0] in_dot [vdq_pkg::SECTOR_COUNT],
  output logic                        out_valid,
  output vdq_pkg::sector_t            out_sector
);
  import vdq_pkg::*;

  localparam int L1N = SECTOR_COUNT / 2;
  localparam int L2N = SECTOR_COUNT / 4;
  localparam int L3N = SECTOR_COUNT / 8;

  logic signed [DOT_WIDTH-1:0] l1_val [L1N];
  sector_t                     l1_idx [L1N];
  logic signed [DOT_WIDTH-1:0] l2_val [L2N];
  sector_t                     l2_idx [L2N];
  logic signed [DOT_WIDTH-1:0] grp_val_r [L2N];
  sector_t                     grp_idx_r [L2N];
  logic                        grp_v_r;
  logic signed [DOT_WIDTH-1:0] l3_val [L3N];
  sector_t                     l3_idx [L3N];
  sector_t                     sector_nxt;
  sector_t                     sector_r;
  logic                        out_v_r;

  // Left operand always holds the lower indices: take the right one only if strictly larger.
  always_comb begin
    for (int i = 0; i < L1N; i++) begin
      if (in_dot[2*i+1] > in_dot[2*i]) begin
        l1_val[i] = in_dot[2*i+1];
        l1_idx[i] = SECTOR_W'(2*i+1);
      end else begin
        l1_val[i] = in_dot[2*i];
        l1_idx[i] = SECTOR_W'(2*i);
      end
    end
    for (int i = 0; i < L2N; i++) begin
      if (l1_val[2*i+1] > l1_val[2*i]) begin
        l2_val[i] = l1_val[2*i+1];
        l2_idx[i] = l1_idx[2*i+1];
      end else begin
        l2_val[i] = l1_val[2*i];
        l2_idx[i] = l1_idx[2*i];
      end
    end
  end

  always_ff @(posedge clk) begin
    grp_val_r <= l2_val;
    grp_idx_r <= l2_idx;
  end

  always_comb begin
    for (int i = 0; i < L3N; i++) begin
      if (grp_val_r[2*i+1] > grp_val_r[2*i]) begin
        l3_val[i] = grp_val_r[2*i+1];
        l3_idx[i] = grp_idx_r[2*i+1];
      end else begin
        l3_val[i] = grp_val_r[2*i];
        l3_idx[i] = grp_idx_r[2*i];
      end
    end
    sector_nxt = (l3_val[1] > l3_val[0]) ? l3_idx[1] : l3_idx[0];
  end

  always_ff @(posedge clk) begin
    sector_r <= sector_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grp_v_r <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      grp_v_r <= in_valid;
      out_v_r <= grp_v_r;
    end
  end

  assign out_valid  = out_v_r;
  assign out_sector = sector_r;

endmodule

### hw/rtl/vector_direction_quantizer16.sv
// Top level of the sixteen-sector vector direction quantizer.
// Depends on vdq_pkg, vdq_dot and vdq_argmax.
//
// Usage:
//   Drive in_vec_x / in_vec_y and raise start; the beat is taken at the
//   rising edge where start is high and busy is low. busy never rises, so
//   a new vector can be taken on every cycle.
//   Each component is narrowed to COMPONENT_WIDTH bits (two's complement
//   wrap below 16 bits, unchanged at 16 or more), then dotted with sixteen
//   Q10 unit vectors at 22.5 degree steps. out_sector gives the index of
//   the largest dot product; ties go to the lowest index, so a zero vector
//   gives sector 0.
//   The result sits on out_sector with out_strobe high for exactly one cycle,
//   once the beat has passed the input register, product register, dot
//   register, group-winner register and result register. Throughput: one
//   beat per cycle, set by the five-stage pipeline with a pair of compare-tree
//   levels in each of the group-winner and result stages.
//   The receiver cannot stall: every result beat is taken when shown.
//   Reset clears all valid bits, dropping any beats in flight; no other
//   state is kept.
module vector_direction_quantizer16 #(
  parameter int COMPONENT_WIDTH = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [vdq_pkg::FIELD_W-1:0]  in_vec_x,
  input  logic signed [vdq_pkg::FIELD_W-1:0]  in_vec_y,
  output logic                                out_strobe,
  output logic [vdq_pkg::SECTOR_W-1:0]        out_sector
);
  import vdq_pkg::*;

  localparam int DotW = COMPONENT_WIDTH + 12;

  logic                              accept;
  logic signed [COMPONENT_WIDTH-1:0] x_nxt;
  logic signed [COMPONENT_WIDTH-1:0] y_nxt;
  logic signed [COMPONENT_WIDTH-1:0] x_r;
  logic signed [COMPONENT_WIDTH-1:0] y_r;
  logic                              in_v_r;
  logic                              dot_valid;
  logic signed [DotW-1:0]            dot [SECTOR_COUNT];
  logic                              res_valid;
  sector_t                           res_sector;

  // Fully pipelined: never hold off the sender.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Narrow (or sign-extend) each component to the working width.
  assign x_nxt = COMPONENT_WIDTH'(in_vec_x);
  assign y_nxt = COMPONENT_WIDTH'(in_vec_y);

  always_ff @(posedge clk) begin
    if (accept) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else begin
      in_v_r <= accept;
    end
  end

  vdq_dot #(
    .COMPONENT_WIDTH (COMPONENT_WIDTH)
  ) u_dot (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_v_r),
    .in_x      (x_r),
    .in_y      (y_r),
    .out_valid (dot_valid),
    .out_dot   (dot)
  );

  vdq_argmax #(
    .DOT_WIDTH (DotW)
  ) u_argmax (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (dot_valid),
    .in_dot     (dot),
    .out_valid  (res_valid),
    .out_sector (res_sector)
  );

  assign out_strobe = res_valid;
  assign out_sector = res_sector;

endmodule
